>>> rtl/core/scs_pkg.sv
// Shared types and constants for the segment collision test core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package scs_pkg;

   localparam int COORD_BITS = 16;
   localparam int R_W        = 16;
   localparam int R2_W       = 2 * R_W;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_PROD   = 10;
   localparam int NUM_SUM    = NUM_PROD / 2;
   localparam int NUM_BOX    = 4;

   // Magnitude of the cross product and the squared length both stay below 2^(2C+1).
   localparam int CM_W       = 2 * COORD_BITS + 1;
   localparam int DD_W       = 2 * COORD_BITS + 1;
   localparam int LO_W       = COORD_BITS;
   localparam int CM_HI_W    = CM_W - LO_W;
   localparam int DD_HI_W    = DD_W - LO_W;
   localparam int CMP_W      = (SUM_W > R2_W) ? SUM_W : R2_W;
   localparam int WIDE_L_W   = 2 * CM_W;
   localparam int WIDE_R_W   = R2_W + DD_W;
   localparam int WIDE_W     = (WIDE_L_W > WIDE_R_W) ? WIDE_L_W : WIDE_R_W;

   // Box flags: which endpoint lies in the bounding box of which segment.
   localparam int BOX_C_IN_AB = 0;
   localparam int BOX_D_IN_AB = 1;
   localparam int BOX_A_IN_CD = 2;
   localparam int BOX_B_IN_CD = 3;

   typedef enum logic {
      REQ_SEG_SEG    = 1'b0,
      REQ_SEG_CIRCLE = 1'b1
   } req_kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      req_kind_type                          kind;
      logic [NUM_BOX-1:0]                    box;
      logic [R_W-1:0]                        radius;
      logic [NUM_PROD-1:0][DIFF_W-1:0]       op_a;
      logic [NUM_PROD-1:0][DIFF_W-1:0]       op_b;
   } item_type;

endpackage

>>> rtl/core/scs_front.sv
// Front end: takes a request, forms coordinate differences, picks multiplier
// operands by request kind and evaluates bounding-box tests. Uses scs_pkg.
`timescale 1ns / 1ps

module scs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  scs_pkg::coord_type  req_seg_a_x,
   input  scs_pkg::coord_type  req_seg_a_y,
   input  scs_pkg::coord_type  req_seg_b_x,
   input  scs_pkg::coord_type  req_seg_b_y,
   input  scs_pkg::coord_type  req_other_c_x,
   input  scs_pkg::coord_type  req_other_c_y,
   input  scs_pkg::coord_type  req_other_d_x,
   input  scs_pkg::coord_type  req_other_d_y,
   input  logic [scs_pkg::R_W-1:0] req_circle_radius,
   input  logic                q_can_push,
   output logic                q_push,
   output scs_pkg::item_type   q_item
);
   import scs_pkg::*;

   typedef logic signed [DIFF_W-1:0] diff_type;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   diff_type abx, aby, acx, acy, adx, ady, cdx, cdy, cax, cay, cbx, cby;

   function automatic logic in_box(coord_type px, coord_type py, coord_type qx,
                                   coord_type qy, coord_type rx, coord_type ry);
      logic ok_x, ok_y;
      ok_x = (rx >= px || rx >= qx) && (rx <= px || rx <= qx);
      ok_y = (ry >= py || ry >= qy) && (ry <= py || ry <= qy);
      return ok_x && ok_y;
   endfunction

   function automatic diff_type sub(coord_type p, coord_type q);
      return diff_type'(p) - diff_type'(q);
   endfunction

   assign q_push   = valid_ff;
   assign busy     = valid_ff && !q_can_push;
   assign accept   = start && !busy;
   assign q_item   = item_ff;
   assign valid_in = accept || (valid_ff && !q_can_push);

   always_comb begin
      abx = sub(req_seg_b_x, req_seg_a_x);
      aby = sub(req_seg_b_y, req_seg_a_y);
      acx = sub(req_other_c_x, req_seg_a_x);
      acy = sub(req_other_c_y, req_seg_a_y);
      adx = sub(req_other_d_x, req_seg_a_x);
      ady = sub(req_other_d_y, req_seg_a_y);
      cdx = sub(req_other_d_x, req_other_c_x);
      cdy = sub(req_other_d_y, req_other_c_y);
      cax = sub(req_seg_a_x, req_other_c_x);
      cay = sub(req_seg_a_y, req_other_c_y);
      cbx = sub(req_seg_b_x, req_other_c_x);
      cby = sub(req_seg_b_y, req_other_c_y);
   end

   always_comb begin
      item_in        = item_ff;
      item_in.kind   = req_kind_type'(req_type);
      item_in.radius = req_circle_radius;
      item_in.box[BOX_C_IN_AB] = in_box(req_seg_a_x, req_seg_a_y, req_seg_b_x, req_seg_b_y,
                                        req_other_c_x, req_other_c_y);
      item_in.box[BOX_D_IN_AB] = in_box(req_seg_a_x, req_seg_a_y, req_seg_b_x, req_seg_b_y,
                                        req_other_d_x, req_other_d_y);
      item_in.box[BOX_A_IN_CD] = in_box(req_other_c_x, req_other_c_y, req_other_d_x,
                                        req_other_d_y, req_seg_a_x, req_seg_a_y);
      item_in.box[BOX_B_IN_CD] = in_box(req_other_c_x, req_other_c_y, req_other_d_x,
                                        req_other_d_y, req_seg_b_x, req_seg_b_y);
      // Each pair of slots is combined in the back end as product(2i) - product(2i+1).
      unique case (item_in.kind)
         REQ_SEG_SEG: begin
            item_in.op_a = '0;
            item_in.op_b = '0;
            // The fifth slot pair (slots 8 and 9) is unused for two segments.
            item_in.op_a[7:0] = {cdy, cdx, cdy, cdx, aby, abx, aby, abx};
            item_in.op_b[7:0] = {cbx, cby, cax, cay, adx, ady, acx, acy};
         end
         REQ_SEG_CIRCLE: begin
            // Squared length, projection, cross product, |C-A|^2, |C-B|^2.
            item_in.op_a = {-cby, cbx, -acy, acx, aby, abx, -acy, acx, -aby, abx};
            item_in.op_b = {cby, cbx, acy, acx, acx, acy, aby, abx, aby, abx};
         end
         default: begin
            item_in.op_a = '0;
            item_in.op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> rtl/core/scs_queue.sv
// Two-entry request queue between the front end and the arithmetic back end.
// Uses scs_pkg for the queued item type.
`timescale 1ns / 1ps

module scs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  scs_pkg::item_type  push_item,
   output logic               can_push,
   output logic               pop,
   output scs_pkg::item_type  pop_item
);
   import scs_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push;

   // The back end never stalls, so any held request leaves in the next cycle.
   assign pop      = (count_ff != 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];
   assign can_push = (count_ff != 2'd2) || pop;
   assign do_push  = push && can_push;

   always_comb begin
      count_in = count_ff;
      priority case ({do_push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/scs_back.sv
// Arithmetic back end: six-stage pipeline of products, cross-product signs,
// nearest-point selection and the exact wide distance compare. Uses scs_pkg.
`timescale 1ns / 1ps

module scs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  scs_pkg::item_type  in_item,
   output logic               rsp_valid,
   output logic               rsp_hit
);
   import scs_pkg::*;

   // Stage 1: products.
   logic                     b1_valid_ff;
   req_kind_type             b1_kind_ff;
   logic [NUM_BOX-1:0]       b1_box_ff;
   logic signed [PROD_W-1:0] b1_prod_ff [NUM_PROD];
   logic [R2_W-1:0]          b1_r2_ff;

   // Stage 2: pairwise differences.
   logic                     b2_valid_ff;
   req_kind_type             b2_kind_ff;
   logic [NUM_BOX-1:0]       b2_box_ff;
   logic signed [SUM_W-1:0]  b2_sum_ff [NUM_SUM];
   logic [R2_W-1:0]          b2_r2_ff;

   // Stage 3: classification.
   logic                     b3_valid_ff;
   logic                     b3_wide_ff, b3_wide_in;
   logic                     b3_fast_ff, b3_fast_in;
   logic [CM_W-1:0]          b3_cm_ff, b3_cm_in;
   logic [DD_W-1:0]          b3_dd_ff;
   logic [R2_W-1:0]          b3_r2_ff;

   // Stage 4: partial products.
   logic                     b4_valid_ff, b4_wide_ff, b4_fast_ff;
   logic [2*CM_HI_W-1:0]     b4_hh_ff;
   logic [CM_HI_W+LO_W-1:0]  b4_hl_ff;
   logic [2*LO_W-1:0]        b4_ll_ff;
   logic [R2_W+DD_HI_W-1:0]  b4_rh_ff;
   logic [R2_W+LO_W-1:0]     b4_rl_ff;

   // Stage 5: wide sums.
   logic                     b5_valid_ff, b5_wide_ff, b5_fast_ff;
   logic [WIDE_W-1:0]        b5_lhs_ff, b5_rhs_ff;

   // Stage 6: result register.
   logic                     rsp_valid_ff, rsp_hit_ff;

   logic signed [SUM_W-1:0]  o1, o2, o3, o4, dd_s, fd_s, cr_s, sqa_s, sqb_s;
   logic [SUM_W-1:0]         cr_mag;
   logic                     seg_cross, seg_hit, near_a, near_b, a_in, b_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   always_comb begin
      o1 = b2_sum_ff[0];
      o2 = b2_sum_ff[1];
      o3 = b2_sum_ff[2];
      o4 = b2_sum_ff[3];
      dd_s  = b2_sum_ff[0];
      fd_s  = b2_sum_ff[1];
      cr_s  = b2_sum_ff[2];
      sqa_s = b2_sum_ff[3];
      sqb_s = b2_sum_ff[4];

      // Proper crossing needs strictly opposite signs on both pairs.
      seg_cross = ((o1 > 0 && o2 < 0) || (o1 < 0 && o2 > 0)) &&
                  ((o3 > 0 && o4 < 0) || (o3 < 0 && o4 > 0));
      seg_hit   = seg_cross ||
                  (o1 == 0 && b2_box_ff[BOX_C_IN_AB]) ||
                  (o2 == 0 && b2_box_ff[BOX_D_IN_AB]) ||
                  (o3 == 0 && b2_box_ff[BOX_A_IN_CD]) ||
                  (o4 == 0 && b2_box_ff[BOX_B_IN_CD]);

      // Nearest point is an endpoint unless the projection falls strictly inside.
      near_a = (dd_s == 0) || (fd_s <= 0);
      near_b = (fd_s >= dd_s);
      a_in   = CMP_W'($unsigned(sqa_s)) <= CMP_W'(b2_r2_ff);
      b_in   = CMP_W'($unsigned(sqb_s)) <= CMP_W'(b2_r2_ff);
      cr_mag = cr_s[SUM_W-1] ? $unsigned(-cr_s) : $unsigned(cr_s);
      b3_cm_in = cr_mag[CM_W-1:0];

      unique case (b2_kind_ff)
         REQ_SEG_SEG: begin
            b3_wide_in = 1'b0;
            b3_fast_in = seg_hit;
         end
         REQ_SEG_CIRCLE: begin
            b3_wide_in = !near_a && !near_b;
            b3_fast_in = near_a ? a_in : b_in;
         end
         default: begin
            b3_wide_in = 1'b0;
            b3_fast_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         b5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= in_valid;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         b5_valid_ff  <= b4_valid_ff;
         rsp_valid_ff <= b5_valid_ff;
      end

      // Stage 1
      b1_kind_ff <= in_item.kind;
      b1_box_ff  <= in_item.box;
      b1_r2_ff   <= R2_W'(in_item.radius) * R2_W'(in_item.radius);
      for (int i = 0; i < NUM_PROD; i++) begin
         b1_prod_ff[i] <= PROD_W'($signed(in_item.op_a[i])) *
                          PROD_W'($signed(in_item.op_b[i]));
      end

      // Stage 2
      b2_kind_ff <= b1_kind_ff;
      b2_box_ff  <= b1_box_ff;
      b2_r2_ff   <= b1_r2_ff;
      for (int i = 0; i < NUM_SUM; i++) begin
         b2_sum_ff[i] <= SUM_W'(b1_prod_ff[2*i]) - SUM_W'(b1_prod_ff[2*i+1]);
      end

      // Stage 3
      b3_wide_ff <= b3_wide_in;
      b3_fast_ff <= b3_fast_in;
      b3_cm_ff   <= b3_cm_in;
      b3_dd_ff   <= dd_s[DD_W-1:0];
      b3_r2_ff   <= b2_r2_ff;

      // Stage 4: cross^2 and r^2 * |B-A|^2 split into narrow partial products.
      b4_wide_ff <= b3_wide_ff;
      b4_fast_ff <= b3_fast_ff;
      b4_hh_ff   <= (2*CM_HI_W)'(b3_cm_ff[CM_W-1:LO_W]) *
                    (2*CM_HI_W)'(b3_cm_ff[CM_W-1:LO_W]);
      b4_hl_ff   <= (CM_HI_W+LO_W)'(b3_cm_ff[CM_W-1:LO_W]) *
                    (CM_HI_W+LO_W)'(b3_cm_ff[LO_W-1:0]);
      b4_ll_ff   <= (2*LO_W)'(b3_cm_ff[LO_W-1:0]) * (2*LO_W)'(b3_cm_ff[LO_W-1:0]);
      b4_rh_ff   <= (R2_W+DD_HI_W)'(b3_r2_ff) * (R2_W+DD_HI_W)'(b3_dd_ff[DD_W-1:LO_W]);
      b4_rl_ff   <= (R2_W+LO_W)'(b3_r2_ff) * (R2_W+LO_W)'(b3_dd_ff[LO_W-1:0]);

      // Stage 5
      b5_wide_ff <= b4_wide_ff;
      b5_fast_ff <= b4_fast_ff;
      b5_lhs_ff  <= (WIDE_W'(b4_hh_ff) << (2*LO_W)) + (WIDE_W'(b4_hl_ff) << (LO_W+1)) +
                    WIDE_W'(b4_ll_ff);
      b5_rhs_ff  <= (WIDE_W'(b4_rh_ff) << LO_W) + WIDE_W'(b4_rl_ff);

      // Stage 6
      rsp_hit_ff <= b5_wide_ff ? (b5_lhs_ff <= b5_rhs_ff) : b5_fast_ff;
   end

endmodule

>>> rtl/core/segment_collision_test_core.sv
// Top level of the segment collision test core: front end, request queue and
// back end. Uses scs_pkg, scs_front, scs_queue and scs_back.
`timescale 1ns / 1ps

// A request is taken at each rising edge where start is high and busy is low.
// Requests may be issued every cycle; one result per request appears on
// rsp_hit with rsp_valid high for a single cycle, once the request has passed
// the front-end register, the queue entry and the back-end stages, in
// request order. The rate of one request per cycle is set by the fully
// pipelined back end, whose products, pairwise differences, classification,
// partial products, wide sums and result each take one stage. Since the
// result port cannot stall, the queue between front and back always drains
// and busy stays low in normal operation. No state is kept between requests.
module segment_collision_test_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  scs_pkg::coord_type  req_seg_a_x,
   input  scs_pkg::coord_type  req_seg_a_y,
   input  scs_pkg::coord_type  req_seg_b_x,
   input  scs_pkg::coord_type  req_seg_b_y,
   input  scs_pkg::coord_type  req_other_c_x,
   input  scs_pkg::coord_type  req_other_c_y,
   input  scs_pkg::coord_type  req_other_d_x,
   input  scs_pkg::coord_type  req_other_d_y,
   input  logic [scs_pkg::R_W-1:0] req_circle_radius,
   output logic                rsp_valid,
   output logic                rsp_hit
);
   import scs_pkg::*;

   logic     q_can_push, q_push, q_pop;
   item_type q_in_item, q_out_item;

   scs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_seg_a_x       (req_seg_a_x),
      .req_seg_a_y       (req_seg_a_y),
      .req_seg_b_x       (req_seg_b_x),
      .req_seg_b_y       (req_seg_b_y),
      .req_other_c_x     (req_other_c_x),
      .req_other_c_y     (req_other_c_y),
      .req_other_d_x     (req_other_d_x),
      .req_other_d_y     (req_other_d_y),
      .req_circle_radius (req_circle_radius),
      .q_can_push        (q_can_push),
      .q_push            (q_push),
      .q_item            (q_in_item)
   );

   scs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .can_push  (q_can_push),
      .pop       (q_pop),
      .pop_item  (q_out_item)
   );

   scs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_pop),
      .in_item   (q_out_item),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit)
   );

endmodule
